### rtl/core/ipv4p_pkg.sv
// Shared types, codes and character helpers for the IPv4 dotted-address parser.
// No dependencies; imported by ipv4p_step and ipv4_dotted_address_parser_unit.
`timescale 1ns / 1ps
`default_nettype none

package ipv4p_pkg;

    localparam int unsigned AddrW    = 32;
    localparam int unsigned CharW    = 8;
    localparam int unsigned NumSaved = 3;
    localparam int unsigned CountW   = 2;

    localparam logic [CharW-1:0] ChNul   = 8'h00;
    localparam logic [CharW-1:0] ChTab   = 8'h09;
    localparam logic [CharW-1:0] ChCr    = 8'h0D;
    localparam logic [CharW-1:0] ChSpace = 8'h20;
    localparam logic [CharW-1:0] ChDot   = 8'h2E;
    localparam logic [CharW-1:0] ChZero  = 8'h30;
    localparam logic [CharW-1:0] ChNine  = 8'h39;
    localparam logic [CharW-1:0] ChUpA   = 8'h41;
    localparam logic [CharW-1:0] ChUpF   = 8'h46;
    localparam logic [CharW-1:0] ChLoA   = 8'h61;
    localparam logic [CharW-1:0] ChLoF   = 8'h66;
    localparam logic [CharW-1:0] ChUpX   = 8'h58;
    localparam logic [CharW-1:0] ChLoX   = 8'h78;

    localparam logic [AddrW-1:0] Max24 = 32'h00FF_FFFF;
    localparam logic [AddrW-1:0] Max16 = 32'h0000_FFFF;
    localparam logic [AddrW-1:0] Max8  = 32'h0000_00FF;

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_ZERO  = 3'd1,
        PH_NUM   = 3'd2,
        PH_DONE  = 3'd3,
        PH_ERR   = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        BASE_DEC = 2'd0,
        BASE_OCT = 2'd1,
        BASE_HEX = 2'd2
    } base_t;

    typedef struct packed {
        logic [CharW-1:0] character;
        logic             last_char;
    } in_item_t;

    typedef struct packed {
        logic             parse_ok;
        logic [AddrW-1:0] address;
    } out_item_t;

    typedef struct packed {
        phase_t            phase;
        logic [AddrW-1:0]  value;
        base_t             base;
        logic [CountW-1:0] part_count;
    } parse_state_t;

    typedef logic [NumSaved-1:0][AddrW-1:0] saved_parts_t;

    typedef struct packed {
        logic              en;
        logic [CountW-1:0] idx;
        logic [AddrW-1:0]  value;
    } save_req_t;

    function automatic logic is_dec(input logic [CharW-1:0] c);
        return (c >= ChZero) && (c <= ChNine);
    endfunction

    function automatic logic is_space(input logic [CharW-1:0] c);
        return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
    endfunction

    function automatic logic is_hex_letter(input logic [CharW-1:0] c);
        return ((c >= ChLoA) && (c <= ChLoF)) || ((c >= ChUpA) && (c <= ChUpF));
    endfunction

endpackage

`default_nettype wire

### rtl/core/ipv4p_step.sv
// One parser step: next state for a character, part save request, and the
// packed result when the character ends the text. Uses ipv4p_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ipv4p_step (
    input  wire ipv4p_pkg::parse_state_t state_cur,
    input  wire ipv4p_pkg::saved_parts_t saved,
    input  wire ipv4p_pkg::in_item_t     item,
    output ipv4p_pkg::parse_state_t      state_next,
    output ipv4p_pkg::save_req_t         save_req,
    output ipv4p_pkg::out_item_t         result
);
    import ipv4p_pkg::*;

    logic [CharW-1:0] c;
    logic [3:0]       digit;
    logic [3:0]       hex_nib;
    base_t            eff_base;
    logic [AddrW-1:0] scaled;
    logic [AddrW-1:0] fin_value;
    logic             fin_done;
    logic             ok;

    assign c       = item.character;
    assign digit   = c[3:0];
    assign hex_nib = c[3:0] + 4'd9;   // 'a'/'A' have low nibble 1

    // after a leading zero the part is octal unless an x follows
    assign eff_base = (state_cur.phase == PH_ZERO) ? BASE_OCT : state_cur.base;

    always_comb begin
        case (eff_base)
            BASE_DEC: scaled = (state_cur.value << 3) + (state_cur.value << 1);
            BASE_OCT: scaled = state_cur.value << 3;
            default:  scaled = state_cur.value << 4;
        endcase
    end

    always_comb begin
        logic num_step;
        num_step   = 1'b0;
        state_next = state_cur;
        save_req   = '{en: 1'b0, idx: state_cur.part_count, value: state_cur.value};

        unique case (state_cur.phase)
            PH_START: begin
                if (!is_dec(c)) begin
                    state_next.phase = PH_ERR;
                end else if (c == ChZero) begin
                    state_next.value = '0;
                    state_next.phase = PH_ZERO;
                end else begin
                    state_next.value = {{(AddrW-4){1'b0}}, digit};
                    state_next.base  = BASE_DEC;
                    state_next.phase = PH_NUM;
                end
            end
            PH_ZERO: begin
                state_next.phase = PH_NUM;
                if (c == ChLoX || c == ChUpX) begin
                    state_next.base = BASE_HEX;
                end else begin
                    state_next.base = BASE_OCT;
                    num_step        = 1'b1;
                end
            end
            PH_NUM:  num_step = 1'b1;
            PH_DONE: ;
            default: state_next.phase = PH_ERR;
        endcase

        if (num_step) begin
            if (is_dec(c)) begin
                state_next.value = scaled + {{(AddrW-4){1'b0}}, digit};
            end else if (eff_base != BASE_DEC && eff_base != BASE_OCT && is_hex_letter(c)) begin
                state_next.value = {state_cur.value[AddrW-5:0], hex_nib};
            end else if (c == ChDot) begin
                if (state_cur.part_count == CountW'(NumSaved)) begin
                    state_next.phase = PH_ERR;
                end else begin
                    save_req.en           = 1'b1;
                    state_next.part_count = state_cur.part_count + 1'b1;
                    state_next.phase      = PH_START;
                end
            end else if (c == ChNul || is_space(c)) begin
                state_next.phase = PH_DONE;
            end else begin
                state_next.phase = PH_ERR;
            end
        end

        // end of text acts as a NUL: any part in progress completes
        fin_value = state_next.value;
        fin_done  = (state_next.phase == PH_ZERO) || (state_next.phase == PH_NUM) ||
                    (state_next.phase == PH_DONE);

        case (state_next.part_count)
            2'd0: ok = 1'b1;
            2'd1: ok = (fin_value <= Max24) && (saved[0] <= Max8);
            2'd2: ok = (fin_value <= Max16) && (saved[0] <= Max8) && (saved[1] <= Max8);
            default: ok = (fin_value <= Max8) && (saved[0] <= Max8) &&
                          (saved[1] <= Max8) && (saved[2] <= Max8);
        endcase
        ok = ok && fin_done;

        result.parse_ok = ok;
        case (state_next.part_count)
            2'd0: result.address = fin_value;
            2'd1: result.address = fin_value | {saved[0][7:0], 24'd0};
            2'd2: result.address = fin_value | {saved[0][7:0], saved[1][7:0], 16'd0};
            default: result.address = fin_value |
                                      {saved[0][7:0], saved[1][7:0], saved[2][7:0], 8'd0};
        endcase
        if (!ok) begin
            result.address = '0;
        end

        if (item.last_char) begin
            state_next.phase      = PH_START;
            state_next.value      = '0;
            state_next.base       = BASE_DEC;
            state_next.part_count = '0;
        end
    end

endmodule

`default_nettype wire

### rtl/core/ipv4_dotted_address_parser_unit.sv
// Streaming inet_aton style IPv4 address parser, one character per item.
// Top level; uses ipv4p_pkg and ipv4p_step.
`timescale 1ns / 1ps
`default_nettype none

// Each character item passes through an input register and the combinational
// parse logic; the item flagged last_char also loads the result register, so
// one result comes out per text, registered once its last character leaves
// the input register. A new item is accepted every cycle; only a last item
// waits, and then only while an earlier result is still unread. Parts may be
// hex (0x), octal (leading 0, digits 8 and 9 also taken) or decimal, in the
// forms a, a.b, a.b.c or a.b.c.d. On error parse_ok is 0 and address is zero.
module ipv4_dotted_address_parser_unit (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  wire ipv4p_pkg::in_item_t  s_item,
    output logic                 m_valid,
    input  wire                  m_ready,
    output ipv4p_pkg::out_item_t m_item
);
    import ipv4p_pkg::*;

    logic         in_valid_reg;
    in_item_t     in_item_reg;
    logic         out_valid_reg;
    out_item_t    out_item_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    saved_parts_t saved_parts_reg;
    save_req_t    save_req;
    out_item_t    result;
    logic         proceed;

    // a non-last item produces nothing, so it never waits on the output side
    assign proceed = in_valid_reg &&
                     (!in_item_reg.last_char || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || proceed;
    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    ipv4p_step u_step (
        .state_cur  (state_reg),
        .saved      (saved_parts_reg),
        .item       (in_item_reg),
        .state_next (state_next),
        .save_req   (save_req),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{phase: PH_START, value: '0, base: BASE_DEC, part_count: '0};
        end else if (proceed) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NumSaved; i++) begin
            if (proceed && save_req.en && save_req.idx == CountW'(i)) begin
                saved_parts_reg[i] <= save_req.value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proceed && in_item_reg.last_char) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proceed && in_item_reg.last_char) begin
            out_item_reg <= result;
        end
    end

`ifndef SYNTHESIS
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_item_reg.parse_ok |-> out_item_reg.address == '0)
        else $error("failed parse carries nonzero address");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        proceed && in_item_reg.last_char |-> !out_valid_reg || m_ready)
        else $error("unread result overwritten");

    a_rearm: assert property (@(posedge aclk) disable iff (!aresetn)
        proceed && in_item_reg.last_char |=>
            state_reg.phase == PH_START && state_reg.part_count == '0)
        else $error("parser not rearmed after end of text");

    a_done_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        proceed && !in_item_reg.last_char && state_reg.phase == PH_DONE |=>
            state_reg.phase == PH_DONE && $stable(state_reg.value))
        else $error("characters after stop changed the value");
`endif

endmodule

`default_nettype wire
